// ===== rtl/lci_pkg.sv =====
`timescale 1ns / 1ps
// lci_pkg: operation, status and cell command codes for the LRU cache index.
// No dependencies; used by the interfaces, lci_cell and lru_cache_index.
package lci_pkg;

    typedef enum logic [1:0] {
        FN_ADD    = 2'd0,
        FN_TOUCH  = 2'd1,
        FN_INVAL  = 2'd2,
        FN_OLDEST = 2'd3
    } func_e_t;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_DUP     = 3'd1,
        STS_MISSING = 3'd2,
        STS_EMPTY   = 3'd3,
        STS_FULL    = 3'd4
    } status_e_t;

    // Command broadcast to every cell in the update cycle.
    typedef enum logic [1:0] {
        CO_NONE   = 2'd0,
        CO_INSERT = 2'd1,
        CO_TOUCH  = 2'd2,
        CO_DROP   = 2'd3
    } cell_op_e_t;

endpackage

// ===== rtl/lci_req_if.sv =====
`timescale 1ns / 1ps
// lci_req_if: request channel of the LRU cache index (valid/ready + payload).
// Depends on lci_pkg.
interface lci_req_if #(
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
);
    logic                     valid;
    logic                     ready;
    lci_pkg::func_e_t         func;
    logic [KEY_BITS-1:0]      key_in;
    logic [PAYLOAD_BITS-1:0]  payload_in;

    modport source (output valid, func, key_in, payload_in, input ready);
    modport sink   (input valid, func, key_in, payload_in, output ready);
endinterface

// ===== rtl/lci_rsp_if.sv =====
`timescale 1ns / 1ps
// lci_rsp_if: response channel of the LRU cache index (valid/ready + payload).
// Depends on lci_pkg.
interface lci_rsp_if #(
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32,
    parameter int CNT_BITS     = 5
);
    logic                     valid;
    logic                     ready;
    lci_pkg::status_e_t       status;
    logic [KEY_BITS-1:0]      key_out;
    logic [PAYLOAD_BITS-1:0]  payload_out;
    logic [CNT_BITS-1:0]      fill_count;

    modport source (output valid, status, key_out, payload_out, fill_count, input ready);
    modport sink   (input valid, status, key_out, payload_out, fill_count, output ready);
endinterface

// ===== rtl/lci_cell.sv =====
`timescale 1ns / 1ps
// lci_cell: one table slot - key, payload, valid mark and recency rank.
// Depends on lci_pkg; instanced once per slot by lru_cache_index.
module lci_cell #(
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32,
    parameter int RANK_BITS    = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lci_pkg::cell_op_e_t      op,
    input  logic                     sel,
    input  logic [RANK_BITS-1:0]     ref_rank,
    input  logic [KEY_BITS-1:0]      key,
    input  logic [PAYLOAD_BITS-1:0]  payload,
    output logic                     hit,
    output logic                     valid,
    output logic [RANK_BITS-1:0]     rank,
    output logic [KEY_BITS-1:0]      key_q,
    output logic [PAYLOAD_BITS-1:0]  payload_q
);
    import lci_pkg::*;

    logic                    valid_reg, valid_next;
    logic [RANK_BITS-1:0]    rank_reg, rank_next;
    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;

    assign hit       = valid_reg && (key_reg == key);
    assign valid     = valid_reg;
    assign rank      = rank_reg;
    assign key_q     = key_reg;
    assign payload_q = payload_reg;

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        unique case (op)
            CO_NONE:
            begin
            end
            CO_INSERT:
            begin
                if (sel)
                begin
                    valid_next = 1'b1;
                    rank_next  = '0;
                end
                else if (valid_reg)
                    rank_next = rank_reg + RANK_BITS'(1);
            end
            CO_TOUCH:
            begin
                if (sel)
                    rank_next = '0;
                else if (valid_reg && rank_reg < ref_rank)
                    rank_next = rank_reg + RANK_BITS'(1);
            end
            CO_DROP:
            begin
                if (sel)
                begin
                    valid_next = 1'b0;
                    rank_next  = '0;
                end
                else if (valid_reg && rank_reg > ref_rank)
                    rank_next = rank_reg - RANK_BITS'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // key/payload need no reset; only read while valid
    always_ff @(posedge clk)
    begin
        if (op == CO_INSERT && sel)
        begin
            key_reg     <= key;
            payload_reg <= payload;
        end
    end

endmodule

// ===== rtl/lru_cache_index.sv =====
`timescale 1ns / 1ps
// lru_cache_index: recency-ordered key/payload table built as a row of lci_cell slots.
// Depends on lci_pkg, lci_req_if, lci_rsp_if and lci_cell.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+--------------------------------------------
//  req     | in  | valid/ready | func, key_in, payload_in
//  rsp     | out | valid/ready | status, key_out, payload_out, fill_count
//
// Each request passes through a lookup cycle (every cell compares its key,
// the oldest and lowest free slot are picked) and an update cycle (the command
// is broadcast to the row of cells and the response register is loaded).
// A new request is taken in the update cycle, so a following request is accepted
// while the last one is still being committed to the cell row.
// Reset clears every valid mark, rank and the fill count at once.
// A stalled response holds the block in its update cycle until rsp.ready.
module lru_cache_index #(
    parameter int ENTRIES      = 16,
    parameter int KEY_BITS     = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    lci_req_if.sink  req,
    lci_rsp_if.source rsp
);
    import lci_pkg::*;

    localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // request holding registers
    func_e_t                 func_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;

    // decision taken in the lookup cycle
    cell_op_e_t              op_reg, op_next;
    logic [ENTRIES-1:0]      sel_reg, sel_next;
    logic [RANK_BITS-1:0]    ref_rank_reg, ref_rank_next;
    status_e_t               status_reg, status_next;
    logic [KEY_BITS-1:0]     kout_reg, kout_next;
    logic [PAYLOAD_BITS-1:0] pout_reg, pout_next;
    logic [CNT_BITS-1:0]     cnt_new_reg, cnt_new_next;

    logic [CNT_BITS-1:0]     count_reg;

    // response register
    logic                    out_valid_reg;
    status_e_t               out_status_reg;
    logic [KEY_BITS-1:0]     out_key_reg;
    logic [PAYLOAD_BITS-1:0] out_pay_reg;
    logic [CNT_BITS-1:0]     out_cnt_reg;

    // cell row
    cell_op_e_t              cell_op;
    logic [ENTRIES-1:0]      hit_vec, valid_vec, free_vec, free_oh, oldest_vec;
    logic [RANK_BITS-1:0]    rank_arr [ENTRIES];
    logic [KEY_BITS-1:0]     ckey_arr [ENTRIES];
    logic [PAYLOAD_BITS-1:0] cpay_arr [ENTRIES];

    logic                    out_free, accept, finish;
    logic                    hit_any;
    logic [CNT_BITS-1:0]     count_m1;
    logic [RANK_BITS-1:0]    old_rank, hit_rank;
    logic [PAYLOAD_BITS-1:0] hit_pay, old_pay;
    logic [KEY_BITS-1:0]     old_key;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign finish    = (state_reg == S_UPD) && out_free;
    assign req.ready = (state_reg == S_IDLE) || finish;
    assign accept    = req.valid && req.ready;
    assign cell_op   = finish ? op_reg : CO_NONE;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            lci_cell #(
                .KEY_BITS     (KEY_BITS),
                .PAYLOAD_BITS (PAYLOAD_BITS),
                .RANK_BITS    (RANK_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .op        (cell_op),
                .sel       (sel_reg[gi]),
                .ref_rank  (ref_rank_reg),
                .key       (key_reg),
                .payload   (payload_reg),
                .hit       (hit_vec[gi]),
                .valid     (valid_vec[gi]),
                .rank      (rank_arr[gi]),
                .key_q     (ckey_arr[gi]),
                .payload_q (cpay_arr[gi])
            );
        end
    endgenerate

    // Ranks of the valid cells always form 0..count-1, so the oldest entry is
    // simply the valid cell whose rank equals count-1.
    assign count_m1 = count_reg - {{(CNT_BITS-1){1'b0}}, 1'b1};
    assign old_rank = count_m1[RANK_BITS-1:0];
    assign free_vec = ~valid_vec;
    assign free_oh  = free_vec & (~free_vec + {{(ENTRIES-1){1'b0}}, 1'b1});
    assign hit_any  = |hit_vec;

    always_comb
    begin
        hit_rank = '0;
        hit_pay  = '0;
        old_key  = '0;
        old_pay  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            oldest_vec[i] = valid_vec[i] && (rank_arr[i] == old_rank);
            if (hit_vec[i])
            begin
                hit_rank = hit_rank | rank_arr[i];
                hit_pay  = hit_pay | cpay_arr[i];
            end
            if (oldest_vec[i])
            begin
                old_key = old_key | ckey_arr[i];
                old_pay = old_pay | cpay_arr[i];
            end
        end
    end

    // lookup decision
    always_comb
    begin
        op_next       = CO_NONE;
        sel_next      = '0;
        ref_rank_next = '0;
        status_next   = STS_OK;
        kout_next     = '0;
        pout_next     = '0;
        cnt_new_next  = count_reg;
        unique case (func_reg)
            FN_ADD:
            begin
                // duplicate check ahead of full check
                if (hit_any)
                    status_next = STS_DUP;
                else if (count_reg == CNT_BITS'(ENTRIES))
                    status_next = STS_FULL;
                else
                begin
                    op_next      = CO_INSERT;
                    sel_next     = free_oh;
                    cnt_new_next = count_reg + {{(CNT_BITS-1){1'b0}}, 1'b1};
                end
            end
            FN_TOUCH:
            begin
                if (!hit_any)
                    status_next = STS_MISSING;
                else
                begin
                    op_next       = CO_TOUCH;
                    sel_next      = hit_vec;
                    ref_rank_next = hit_rank;
                end
            end
            FN_INVAL:
            begin
                if (!hit_any)
                    status_next = STS_MISSING;
                else
                begin
                    op_next       = CO_DROP;
                    sel_next      = hit_vec;
                    ref_rank_next = hit_rank;
                    pout_next     = hit_pay;
                    cnt_new_next  = count_m1;
                end
            end
            FN_OLDEST:
            begin
                if (count_reg == '0)
                    status_next = STS_EMPTY;
                else
                begin
                    op_next       = CO_DROP;
                    sel_next      = oldest_vec;
                    ref_rank_next = old_rank;
                    kout_next     = old_key;
                    pout_next     = old_pay;
                    cnt_new_next  = count_m1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_LOOK;
            S_LOOK:
                state_next = S_UPD;
            S_UPD:
                if (finish)
                    state_next = accept ? S_LOOK : S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                count_reg     <= cnt_new_reg;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= req.func;
            key_reg     <= req.key_in;
            payload_reg <= req.payload_in;
        end
        if (state_reg == S_LOOK)
        begin
            op_reg       <= op_next;
            sel_reg      <= sel_next;
            ref_rank_reg <= ref_rank_next;
            status_reg   <= status_next;
            kout_reg     <= kout_next;
            pout_reg     <= pout_next;
            cnt_new_reg  <= cnt_new_next;
        end
        if (finish)
        begin
            out_status_reg <= status_reg;
            out_key_reg    <= kout_reg;
            out_pay_reg    <= pout_reg;
            out_cnt_reg    <= cnt_new_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.key_out     = out_key_reg;
    assign rsp.payload_out = out_pay_reg;
    assign rsp.fill_count  = out_cnt_reg;

endmodule
